/* sv/assert_macros.svh */
// Assertion macros used by the allocator sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checks that a condition holds on every rising clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
// Checks that a consequence holds in the cycle after its trigger.
`define ASSERT_NEXT(lbl, clk, rst_n, trig, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define ASSERT_NEXT(lbl, clk, rst_n, trig, cons)
`endif
`endif

/* sv/bra_pkg.sv */
// Shared codes, constants and control types of the bitmap run allocator.
package bra_pkg;

    localparam int POOL_BITS_DEF = 256;

    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;
    localparam logic [1:0] REQ_STATS = 2'd3;

    localparam logic CFG_BEST_FIT = 1'b0;
    localparam logic CFG_ACTIVE   = 1'b1;

    typedef struct packed {
        logic load;          // capture the accepted request
        logic ctr_zero;      // restart the sweep counter
        logic scan_init;     // restart counter and scan accumulators
        logic srch;          // with scan_init: this scan searches for a fit
        logic issue;         // read the occupancy bit at the counter
        logic clr;           // write zero to both stores at the counter
        logic mark;          // write one run bit at base plus counter
        logic commit_alloc;
        logic commit_free;
        logic commit_clear;
        logic commit_stats;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] req;
        logic       alloc_bad;
        logic       found;
        logic       free_match;
        logic       issue_end;
        logic       pend;        // a scan read is still in flight
        logic       mark_last;
        logic       clr_last;
        logic       out_free;
    } t_sts;

endpackage

/* sv/bra_ctrl.sv */
// Request sequencer of the bitmap run allocator.
`include "assert_macros.svh"
module bra_ctrl
    import bra_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_A0    = 4'd2;
    localparam logic [3:0] S_SCAN1 = 4'd3;
    localparam logic [3:0] S_F1    = 4'd4;
    localparam logic [3:0] S_F2    = 4'd5;
    localparam logic [3:0] S_MARK  = 4'd6;
    localparam logic [3:0] S_SCAN2 = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;
    localparam logic [3:0] S_STATS = 4'd9;

    logic [3:0] r_state, n_state;
    logic       r_boot, n_boot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_boot  <= 1'b1;
        end else begin
            r_state <= n_state;
            r_boot  <= n_boot;
        end
    end

    always_comb begin
        n_state = r_state;
        n_boot  = r_boot;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr   = 1'b1;
                o_cmd.issue = 1'b0;
                if (i_sts.clr_last) begin
                    o_cmd.commit_clear = 1'b1;
                    n_boot = 1'b0;
                    if (r_boot) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.scan_init = 1'b1;
                        n_state = S_SCAN2;
                    end
                end
            end
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load     = 1'b1;
                    o_cmd.ctr_zero = 1'b1;
                    n_state        = S_STATS;
                    case (i_sts.req)
                        REQ_ALLOC: n_state = S_A0;
                        REQ_FREE:  n_state = S_F1;
                        REQ_CLEAR: n_state = S_CLR;
                        default:   n_state = S_STATS;
                    endcase
                end
            end
            S_STATS: begin
                o_cmd.commit_stats = 1'b1;
                o_cmd.scan_init    = 1'b1;
                n_state            = S_SCAN2;
            end
            S_A0: begin
                o_cmd.scan_init = 1'b1;
                if (i_sts.alloc_bad) begin
                    n_state = S_SCAN2;
                end else begin
                    o_cmd.srch = 1'b1;
                    n_state    = S_SCAN1;
                end
            end
            S_SCAN1: begin
                o_cmd.issue = !i_sts.issue_end;
                if (i_sts.issue_end && !i_sts.pend) begin
                    if (i_sts.found) begin
                        o_cmd.ctr_zero = 1'b1;
                        n_state = S_MARK;
                    end else begin
                        o_cmd.scan_init = 1'b1;
                        n_state = S_SCAN2;
                    end
                end
            end
            S_F1: n_state = S_F2;
            S_F2: begin
                if (i_sts.free_match) begin
                    o_cmd.ctr_zero = 1'b1;
                    n_state = S_MARK;
                end else begin
                    o_cmd.scan_init = 1'b1;
                    n_state = S_SCAN2;
                end
            end
            S_MARK: begin
                o_cmd.mark = 1'b1;
                if (i_sts.mark_last) begin
                    o_cmd.commit_alloc = (i_sts.req == REQ_ALLOC);
                    o_cmd.commit_free  = (i_sts.req == REQ_FREE);
                    o_cmd.scan_init    = 1'b1;
                    n_state = S_SCAN2;
                end
            end
            S_SCAN2: begin
                o_cmd.issue = !i_sts.issue_end;
                if (i_sts.issue_end && !i_sts.pend) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    `ASSERT_NEXT(a_hold_done, i_clk, i_rst_n, (r_state == S_DONE) && !i_sts.out_free, r_state == S_DONE)
    `ASSERT_ALWAYS(a_mark_req, i_clk, i_rst_n, (r_state != S_MARK) || (i_sts.req == REQ_ALLOC) || (i_sts.req == REQ_FREE))
    `ASSERT_NEXT(a_busy_after_load, i_clk, i_rst_n, o_cmd.load, r_state != S_IDLE)

endmodule

/* sv/bra_dp.sv */
// Datapath of the bitmap run allocator: stores, run scanner, counters, result register.
module bra_dp
    import bra_pkg::*;
#(
    parameter int POOL_BITS = POOL_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_idx,
    input  logic [8:0]   i_cfg_wdata,
    input  logic [1:0]   i_req_type,
    input  logic [8:0]   i_run_length,
    input  logic [7:0]   i_run_start,
    input  t_cmd         i_cmd,
    output t_sts         o_sts,
    output logic         o_valid,
    input  logic         i_ready,
    output logic         o_ok,
    output logic [7:0]   o_granted_start,
    output logic [8:0]   o_granted_length,
    output logic [8:0]   o_used_total,
    output logic [8:0]   o_largest_free_run,
    output logic         o_frag_warning,
    output logic [31:0]  o_alloc_count,
    output logic [31:0]  o_free_count,
    output logic [8:0]   o_peak_used
);

    localparam int AW = (POOL_BITS > 1) ? $clog2(POOL_BITS) : 1;
    localparam int LW = ($clog2(POOL_BITS + 1) > 9) ? $clog2(POOL_BITS + 1) : 9;

    logic           r_best;
    logic [8:0]     r_active;
    logic [1:0]     r_req;
    logic [LW-1:0]  r_len;
    logic [7:0]     r_st;
    logic [LW-1:0]  r_ctr;
    logic           r_pv;
    logic [LW-1:0]  r_pidx;
    logic           r_plast;
    logic           r_srch;
    logic [LW-1:0]  r_cur_len, r_cur_st, r_big, r_zeros, r_pick;
    logic [LW:0]    r_bestsz;
    logic           r_found;
    logic [LW-1:0]  r_used, r_peak;
    logic [31:0]    r_allocs, r_frees;
    logic           r_ok;
    logic           r_ovalid;

    logic           r_occ [POOL_BITS];
    logic [LW-1:0]  r_tab [POOL_BITS];
    logic           r_occ_q;
    logic [LW-1:0]  r_tab_q;

    logic [LW-1:0]  span, span_m1, st_ext, base, new_len, run_st, closed_len, closed_st;
    logic [LW-1:0]  n_used_add;
    logic [LW:0]    msum;
    logic           is_free, occ_we, occ_wd, tab_we, warn;
    logic [AW-1:0]  occ_wa, tab_wa;
    logic [LW-1:0]  tab_wd;

    always_comb begin
        if (r_active == 9'd0) begin
            span = LW'(1);
        end else if ({{(LW-9){1'b0}}, r_active} > LW'(POOL_BITS)) begin
            span = LW'(POOL_BITS);
        end else begin
            span = {{(LW-9){1'b0}}, r_active};
        end
    end

    assign span_m1    = span - LW'(1);
    assign st_ext     = {{(LW-8){1'b0}}, r_st};
    assign base       = (r_req == REQ_ALLOC) ? r_pick : st_ext;
    assign msum       = {1'b0, base} + {1'b0, r_ctr};
    assign n_used_add = r_used + r_len;

    // Run tracking: a run closes at an occupied bit or at the last active bit.
    assign is_free    = !r_occ_q;
    assign new_len    = is_free ? (r_cur_len + LW'(1)) : '0;
    assign run_st     = (r_cur_len == '0) ? r_pidx : r_cur_st;
    assign closed_len = is_free ? (r_plast ? new_len : '0) : r_cur_len;
    assign closed_st  = is_free ? run_st : r_cur_st;

    assign o_sts.req        = r_req;
    assign o_sts.alloc_bad  = (r_len == '0) || (r_len > span);
    assign o_sts.found      = r_found;
    assign o_sts.free_match = (st_ext < LW'(POOL_BITS)) && (r_tab_q != '0) && (r_tab_q == r_len);
    assign o_sts.issue_end  = (r_ctr == span);
    assign o_sts.pend       = r_pv;
    assign o_sts.mark_last  = (r_ctr == r_len - LW'(1)) || (msum == (LW+1)'(POOL_BITS - 1));
    assign o_sts.clr_last   = (r_ctr == LW'(POOL_BITS - 1));
    assign o_sts.out_free   = !r_ovalid || i_ready;

    assign occ_we = i_cmd.clr || i_cmd.mark;
    assign occ_wa = i_cmd.clr ? r_ctr[AW-1:0] : msum[AW-1:0];
    assign occ_wd = !i_cmd.clr && (r_req == REQ_ALLOC);
    assign tab_we = i_cmd.clr || i_cmd.commit_alloc || i_cmd.commit_free;
    assign tab_wa = i_cmd.clr ? r_ctr[AW-1:0] : base[AW-1:0];
    assign tab_wd = i_cmd.commit_alloc ? r_len : '0;

    always_ff @(posedge i_clk) begin
        if (occ_we) begin
            r_occ[occ_wa] <= occ_wd;
        end
        r_occ_q <= r_occ[r_ctr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (tab_we) begin
            r_tab[tab_wa] <= tab_wd;
        end
        r_tab_q <= r_tab[st_ext[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best <= 1'b0;
            r_active <= 9'd256;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_BEST_FIT) begin
                r_best <= i_cfg_wdata[0];
            end else begin
                r_active <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req_type;
            r_len <= {{(LW-9){1'b0}}, i_run_length};
            r_st  <= i_run_start;
        end
    end

    // Counter and scan pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctr <= '0;
            r_pv  <= 1'b0;
        end else begin
            r_pv <= i_cmd.issue;
            if (i_cmd.ctr_zero || i_cmd.scan_init) begin
                r_ctr <= '0;
            end else if (i_cmd.issue || i_cmd.clr || i_cmd.mark) begin
                r_ctr <= r_ctr + LW'(1);
            end
        end
    end

    // The chosen start is kept through the closing scan so that the result can report it.
    always_ff @(posedge i_clk) begin
        r_pidx  <= r_ctr;
        r_plast <= (r_ctr == span_m1);
        if (i_cmd.scan_init) begin
            r_srch    <= i_cmd.srch;
            r_cur_len <= '0;
            r_cur_st  <= '0;
            r_big     <= '0;
            r_zeros   <= '0;
            r_found   <= 1'b0;
            r_bestsz  <= {1'b0, span} + (LW+1)'(1);
        end else if (r_pv) begin
            r_cur_len <= new_len;
            r_cur_st  <= is_free ? run_st : r_cur_st;
            r_zeros   <= r_zeros + {{(LW-1){1'b0}}, is_free};
            if (closed_len > r_big) begin
                r_big <= closed_len;
            end
            if (r_srch && closed_len != '0 && closed_len >= r_len) begin
                if (r_best) begin
                    if ({1'b0, closed_len} < r_bestsz) begin
                        r_bestsz <= {1'b0, closed_len};
                        r_pick   <= closed_st;
                        r_found  <= 1'b1;
                    end
                end else if (!r_found) begin
                    r_pick  <= closed_st;
                    r_found <= 1'b1;
                end
            end
        end
    end

    // Usage and statistics.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r_peak   <= '0;
            r_allocs <= '0;
            r_frees  <= '0;
            r_ok     <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_ok <= 1'b0;
            end
            if (i_cmd.commit_alloc) begin
                r_used   <= n_used_add;
                r_allocs <= r_allocs + 32'd1;
                if (n_used_add > r_peak) begin
                    r_peak <= n_used_add;
                end
                r_ok <= 1'b1;
            end
            if (i_cmd.commit_free) begin
                r_used  <= (r_used >= r_len) ? (r_used - r_len) : '0;
                r_frees <= r_frees + 32'd1;
                r_ok    <= 1'b1;
            end
            if (i_cmd.commit_clear) begin
                r_used <= '0;
                r_ok   <= 1'b1;
            end
            if (i_cmd.commit_stats) begin
                r_allocs <= '0;
                r_frees  <= '0;
                r_peak   <= '0;
                r_ok     <= 1'b1;
            end
        end
    end

    assign warn = r_ok && (r_req == REQ_ALLOC || r_req == REQ_FREE) && (r_used != '0)
                  && (r_zeros != '0) && ({r_big, 2'b00} < {2'b00, r_zeros});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_ok               <= r_ok;
            o_granted_start    <= (r_ok && r_req != REQ_CLEAR && r_req != REQ_STATS)
                                  ? base[7:0] : 8'd0;
            o_granted_length   <= (r_ok && r_req != REQ_CLEAR && r_req != REQ_STATS)
                                  ? r_len[8:0] : 9'd0;
            o_used_total       <= r_used[8:0];
            o_largest_free_run <= r_big[8:0];
            o_frag_warning     <= warn;
            o_alloc_count      <= r_allocs;
            o_free_count       <= r_frees;
            o_peak_used        <= r_peak[8:0];
        end
    end

    assign o_valid = r_ovalid;

endmodule

/* sv/bitmap_run_allocator.sv */
// Top level of the bitmap run allocator: stream ports around sequencer and datapath.
//
// The block hands out contiguous runs of bits from a pool and frees them again. Each
// request transaction yields exactly one result transaction. A request walks the pool
// one bit per cycle through the occupancy memory; below, the span is active_bits held
// to the range 1 to POOL_BITS. A successful allocate scans the span to find a run
// (first fit or best fit), marks the run one bit per cycle, then scans again to report
// the largest free run; the next request can be taken as soon as its result is in the
// output register. A successful free reads the length table, clears the run bit by bit
// and rescans; a statistics clear resets the counters and rescans, and a failed request
// skips the marking. A pool clear sweeps both stores one entry per cycle, then rescans.
// While an earlier result still waits in the output register, the new result is not
// written. After reset the same sweep runs before the first request is taken;
// configuration writes are taken at any time but should be made only while idle.
// A finished result sits in an output register, so the next request is accepted while
// the previous result waits for the downstream side.
module bitmap_run_allocator
    import bra_pkg::*;
#(
    parameter int POOL_BITS = POOL_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic         i_cfg_idx,
    input  logic [8:0]   i_cfg_wdata,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [23:0]  s_axis_tdata,  // run_length[8:0], run_start[16:9], zero fill
    input  logic [1:0]   s_axis_tuser,  // req_type[1:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // granted_start[7:0], granted_length[16:8], used_total[25:17],
    // largest_free_run[34:26], frag_warning[35], alloc_count[67:36],
    // free_count[99:68], peak_used[108:100], zero fill
    output logic [111:0] m_axis_tdata,
    output logic         m_axis_tuser   // ok[0]
);

    t_cmd cmd;
    t_sts sts;

    logic [7:0]  gs;
    logic [8:0]  gl, used, largest, peak;
    logic        warn;
    logic [31:0] allocs, frees;

    // The request kind is sampled straight from the port while idle, so the sequencer
    // can branch on it at the accepting edge.
    t_sts sts_ctrl;
    always_comb begin
        sts_ctrl = sts;
        if (s_axis_tready) begin
            sts_ctrl.req = s_axis_tuser;
        end
    end

    bra_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_sts   (sts_ctrl),
        .o_cmd   (cmd)
    );

    bra_dp #(
        .POOL_BITS (POOL_BITS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_req_type         (s_axis_tuser),
        .i_run_length       (s_axis_tdata[8:0]),
        .i_run_start        (s_axis_tdata[16:9]),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .o_valid            (m_axis_tvalid),
        .i_ready            (m_axis_tready),
        .o_ok               (m_axis_tuser),
        .o_granted_start    (gs),
        .o_granted_length   (gl),
        .o_used_total       (used),
        .o_largest_free_run (largest),
        .o_frag_warning     (warn),
        .o_alloc_count      (allocs),
        .o_free_count       (frees),
        .o_peak_used        (peak)
    );

    assign m_axis_tdata = {3'b000, peak, frees, allocs, warn, largest, used, gl, gs};

endmodule

/* sim/bitmap_run_allocator_tb.sv */
// Self-checking testbench for the bitmap run allocator, with random requests and stalls.
module bitmap_run_allocator_tb
    import bra_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NPOOL = 256;

    typedef struct packed {
        logic        ok;
        logic [7:0]  gstart;
        logic [8:0]  glen;
        logic [8:0]  used;
        logic [8:0]  largest;
        logic        warn;
        logic [31:0] allocs;
        logic [31:0] frees;
        logic [8:0]  peak;
    } t_grant;

    // Scoreboard: a private copy of the allocator state and a queue of predicted grants.
    class grant_board;
        bit          best_fit;
        int unsigned active;
        bit          occ [NPOOL];
        int unsigned runlen [NPOOL];
        int unsigned used_n, peak_n;
        bit [31:0]   allocs_n, frees_n;
        t_grant      pending [$];
        int          errors;

        function new();
            best_fit = 0;
            active = 256;
            foreach (occ[i]) begin
                occ[i] = 0;
                runlen[i] = 0;
            end
            used_n = 0;
            peak_n = 0;
            allocs_n = 0;
            frees_n = 0;
            errors = 0;
        endfunction

        function int unsigned span();
            if (active < 1) return 1;
            if (active > NPOOL) return NPOOL;
            return active;
        endfunction

        // Walks the active bits; gives largest free run, free count and the chosen start.
        function void sweep(int unsigned need, output int unsigned big, output int unsigned zeros,
                            output bit found, output int unsigned pick);
            int unsigned n, i, st, len, bestsz;
            n = span();
            i = 0;
            big = 0;
            zeros = 0;
            bestsz = n + 1;
            found = 0;
            pick = 0;
            while (i < n) begin
                if (occ[i]) begin
                    i++;
                end else begin
                    st = i;
                    len = 0;
                    while (i < n && !occ[i]) begin
                        len++;
                        i++;
                    end
                    zeros += len;
                    if (len > big) big = len;
                    if (need != 0 && len >= need) begin
                        if (best_fit) begin
                            if (len < bestsz) begin
                                bestsz = len;
                                pick = st;
                                found = 1;
                            end
                        end else if (!found) begin
                            pick = st;
                            found = 1;
                        end
                    end
                end
            end
        endfunction

        function void configure(bit idx, bit [8:0] val);
            if (idx == CFG_BEST_FIT) best_fit = val[0];
            else active = val;
        endfunction

        function void note_request(logic [1:0] req, int unsigned len, int unsigned st);
            t_grant g;
            int unsigned big, zeros, pick;
            bit found;
            g = '0;
            if (req == REQ_ALLOC) begin
                if (len != 0 && len <= span()) begin
                    sweep(len, big, zeros, found, pick);
                    if (found) begin
                        for (int k = 0; k < len && pick + k < NPOOL; k++) occ[pick + k] = 1;
                        runlen[pick] = len;
                        used_n += len;
                        allocs_n++;
                        if (used_n > peak_n) peak_n = used_n;
                        g.ok = 1;
                        g.gstart = 8'(pick);
                        g.glen = 9'(len);
                    end
                end
            end else if (req == REQ_FREE) begin
                if (runlen[st] != 0 && runlen[st] == len) begin
                    for (int k = 0; k < len && st + k < NPOOL; k++) occ[st + k] = 0;
                    runlen[st] = 0;
                    used_n = (used_n >= len) ? used_n - len : 0;
                    frees_n++;
                    g.ok = 1;
                    g.gstart = 8'(st);
                    g.glen = 9'(len);
                end
            end else if (req == REQ_CLEAR) begin
                foreach (occ[i]) begin
                    occ[i] = 0;
                    runlen[i] = 0;
                end
                used_n = 0;
                g.ok = 1;
            end else begin
                allocs_n = 0;
                frees_n = 0;
                peak_n = 0;
                g.ok = 1;
            end
            sweep(0, big, zeros, found, pick);
            g.warn = g.ok && req <= REQ_FREE && used_n > 0 && zeros > 0 && 4 * big < zeros;
            g.used = 9'(used_n);
            g.largest = 9'(big);
            g.allocs = allocs_n;
            g.frees = frees_n;
            g.peak = 9'(peak_n);
            pending.push_back(g);
        endfunction

        task report(string what, longint unsigned got, longint unsigned want);
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        task check_grant(t_grant got);
            t_grant w;
            if (pending.size() == 0) begin
                report("unexpected result", 1, 0);
                return;
            end
            w = pending.pop_front();
            if (got.ok != w.ok) report("ok", got.ok, w.ok);
            if (got.gstart != w.gstart) report("granted_start", got.gstart, w.gstart);
            if (got.glen != w.glen) report("granted_length", got.glen, w.glen);
            if (got.used != w.used) report("used_total", got.used, w.used);
            if (got.largest != w.largest) report("largest_free_run", got.largest, w.largest);
            if (got.warn != w.warn) report("frag_warning", got.warn, w.warn);
            if (got.allocs != w.allocs) report("alloc_count", got.allocs, w.allocs);
            if (got.frees != w.frees) report("free_count", got.frees, w.frees);
            if (got.peak != w.peak) report("peak_used", got.peak, w.peak);
        endtask
    endclass

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         i_cfg_we = 0;
    logic         i_cfg_idx = 0;
    logic [8:0]   i_cfg_wdata = 0;
    logic         s_axis_tvalid = 0;
    logic         s_axis_tready;
    logic [23:0]  s_axis_tdata = 0;  // run_length[8:0], run_start[16:9], zero fill
    logic [1:0]   s_axis_tuser = 0;  // req_type[1:0]
    logic         m_axis_tvalid;
    logic         m_axis_tready = 0;
    // granted_start[7:0], granted_length[16:8], used_total[25:17],
    // largest_free_run[34:26], frag_warning[35], alloc_count[67:36],
    // free_count[99:68], peak_used[108:100], zero fill
    logic [111:0] m_axis_tdata;
    logic         m_axis_tuser;      // ok[0]

    bitmap_run_allocator uut (.*);

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    grant_board board = new();
    bit quiet_tail = 0;     // no idling in the last part of the run
    bit hold_off = 0;       // long receiver stall requested by the stimulus
    int seen_runs_start [$];
    int seen_runs_len [$];

    // Receiver: random ready bursts, one long hold-off, and a check on every transaction.
    initial begin : sink
        int gap;
        forever begin
            @(negedge i_clk);
            if (hold_off) begin
                m_axis_tready <= 0;
                repeat (3000) @(negedge i_clk);
                hold_off = 0;
            end
            if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 7);
                m_axis_tready <= 0;
                repeat (gap - 1) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_grant got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '0;
            got.ok = m_axis_tuser;
            got.gstart = m_axis_tdata[7:0];
            got.glen = m_axis_tdata[16:8];
            got.used = m_axis_tdata[25:17];
            got.largest = m_axis_tdata[34:26];
            got.warn = m_axis_tdata[35];
            got.allocs = m_axis_tdata[67:36];
            got.frees = m_axis_tdata[99:68];
            got.peak = m_axis_tdata[108:100];
            board.check_grant(got);
        end
    end

    // Offers one request and waits for its transaction; idles before it at random.
    task automatic send_request(logic [1:0] req, logic [8:0] len, logic [7:0] st);
        if (!quiet_tail && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser <= req;
        s_axis_tdata <= {7'd0, st, len};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_request(req, len, st);
        if (req == REQ_ALLOC && board.pending[$].ok) begin
            seen_runs_start.push_back(board.pending[$].gstart);
            seen_runs_len.push_back(len);
        end
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (board.pending.size() != 0) @(negedge i_clk);
        repeat (600) @(negedge i_clk);
    endtask

    task automatic write_reg(bit idx, logic [8:0] val);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we <= 0;
        board.configure(idx, val);
    endtask

    // Random request mix, weighted towards allocates and frees of live runs.
    task automatic random_request();
        int pick, k;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            send_request(REQ_ALLOC, ($urandom_range(0, 9) == 0) ? 9'($urandom_range(0, 511))
                                                               : 9'($urandom_range(1, 24)),
                         8'd0);
        end else if (pick < 85 && seen_runs_start.size() != 0) begin
            k = $urandom_range(0, seen_runs_start.size() - 1);
            send_request(REQ_FREE, 9'(seen_runs_len[k]), 8'(seen_runs_start[k]));
            seen_runs_start.delete(k);
            seen_runs_len.delete(k);
        end else if (pick < 93) begin
            send_request(REQ_FREE, 9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)));
        end else if (pick < 97) begin
            send_request(REQ_CLEAR, 9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)));
            seen_runs_start.delete();
            seen_runs_len.delete();
        end else begin
            send_request(REQ_STATS, 9'($urandom_range(0, 511)), 8'($urandom_range(0, 255)));
        end
    endtask

    initial begin : stimulus
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1;
        // Directed part: extremes, every request kind and corner cases.
        send_request(REQ_ALLOC, 0, 0);
        send_request(REQ_ALLOC, 257, 0);
        send_request(REQ_ALLOC, 511, 255);
        send_request(REQ_ALLOC, 256, 0);
        send_request(REQ_ALLOC, 1, 0);
        send_request(REQ_FREE, 256, 0);
        send_request(REQ_ALLOC, 1, 0);
        send_request(REQ_FREE, 5, 0);
        send_request(REQ_FREE, 0, 3);
        send_request(REQ_ALLOC, 10, 0);
        send_request(REQ_ALLOC, 3, 0);
        send_request(REQ_ALLOC, 20, 0);
        send_request(REQ_FREE, 10, 0);
        send_request(REQ_STATS, 0, 0);
        send_request(REQ_CLEAR, 511, 255);
        seen_runs_start.delete();
        seen_runs_len.delete();
        drain();
        // Best fit with a shrunk pool; a run beyond the new limit stays freeable.
        send_request(REQ_ALLOC, 200, 0);
        drain();
        write_reg(CFG_BEST_FIT, 1);
        write_reg(CFG_ACTIVE, 100);
        send_request(REQ_FREE, 200, 0);
        send_request(REQ_ALLOC, 30, 0);
        send_request(REQ_ALLOC, 8, 0);
        send_request(REQ_FREE, 30, 0);
        send_request(REQ_ALLOC, 5, 0);
        drain();
        write_reg(CFG_ACTIVE, 0);
        send_request(REQ_ALLOC, 1, 0);
        drain();
        write_reg(CFG_ACTIVE, 511);
        send_request(REQ_CLEAR, 0, 0);
        seen_runs_start.delete();
        seen_runs_len.delete();

        // Random phases under different settings.
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            write_reg(CFG_BEST_FIT, 9'($urandom_range(0, 1)));
            write_reg(CFG_ACTIVE, (ph == 0) ? 9'd256 : (ph == 1) ? 9'd1
                                                                : 9'($urandom_range(16, 256)));
            for (int n = 0; n < 90; n++) begin
                if (ph == 2 && n == 10) hold_off = 1;
                if (ph == 5 && n == 50) quiet_tail = 1;
                random_request();
            end
        end
        drain();
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #40ms;
        $display("Simulation FAILED");
        $finish;
    end
endmodule
